[rtl/cyclic_color_keyframe_ramp_defines.svh]
// Assertion macros for the cyclic colour keyframe ramp checker.
// Expects clk_i and rst_ni to be visible where the macros are used.
`ifndef CYCLIC_COLOR_KEYFRAME_RAMP_DEFINES_SVH
`define CYCLIC_COLOR_KEYFRAME_RAMP_DEFINES_SVH

// Clocked check, switched off while reset is asserted
`define CCKR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define CCKR_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/cckr_pkg.sv]
// Shared types, constants and helpers for the cyclic colour keyframe ramp.
// No dependencies; used by every other file of the block but the macro header.
package cckr_pkg;

  // Table and time format
  localparam int MAX_KEYFRAMES  = 16;
  localparam int TIME_FRAC_BITS = 16;
  localparam int TIME_W         = TIME_FRAC_BITS + 1;
  localparam int SPAN_W         = TIME_W + 1;
  localparam int SLOT_W         = $clog2(MAX_KEYFRAMES);
  localparam int COUNT_W        = 5;
  localparam int COLOR_W        = 32;
  localparam int CHAN_W         = 8;
  localparam int DIV_CNT_W      = $clog2(TIME_FRAC_BITS);
  localparam int BLEND_W        = CHAN_W + TIME_W + 1;

  localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(1) << TIME_FRAC_BITS;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_KEYFRAME_COUNT = 1'b0;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   key_time;
    logic [COLOR_W-1:0]  key_color;
    logic [TIME_W-1:0]   time_of_day;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              wr_en;
    logic              query;
    logic [SLOT_W-1:0] rd_addr;
    logic              take_first;
    logic              set_zero;
    logic              set_single;
    logic              load_seg;
    logic              load_wrap;
    logic              advance;
    logic              div_fix;
    logic              div_step;
    logic              load_out;
  } cckr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic div_trivial;
  } cckr_stat_t;

  // Clamp a time to one day
  function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] t);
    sat_time = (t > TIME_ONE) ? TIME_ONE : t;
  endfunction

endpackage

[rtl/cckr_datapath.sv]
// Datapath of the keyframe ramp: keyframe memories, segment registers,
// restoring divider for the blend fraction and the channel blend. Uses cckr_pkg.
module cckr_datapath
  import cckr_pkg::*;
(
  input  logic       clk_i,
  input  in_item_t   in_data_i,
  input  cckr_cmd_t  cmd_i,
  output cckr_stat_t stat_o,
  output out_item_t  out_data_o
);

  logic [TIME_W-1:0]  time_mem  [MAX_KEYFRAMES];
  logic [COLOR_W-1:0] color_mem [MAX_KEYFRAMES];

  logic [TIME_W-1:0]  rd_time_q;
  logic [COLOR_W-1:0] rd_color_q;
  logic [TIME_W-1:0]  t_q;
  logic [TIME_W-1:0]  first_time_q;
  logic [COLOR_W-1:0] first_color_q;
  logic [TIME_W-1:0]  prev_time_q;
  logic [COLOR_W-1:0] prev_color_q;
  logic [COLOR_W-1:0] from_q;
  logic [COLOR_W-1:0] to_q;
  logic [SPAN_W-1:0]  rem_q;
  logic [SPAN_W-1:0]  span_q;
  logic [TIME_W-1:0]  u_q;
  out_item_t          out_q;

  logic [SPAN_W-1:0]  seg_num;
  logic [SPAN_W-1:0]  seg_span;
  logic [SPAN_W-1:0]  wrap_num;
  logic [SPAN_W-1:0]  wrap_span;
  logic [SPAN_W:0]    rem_shift;
  logic               q_bit;
  logic [SPAN_W-1:0]  rem_d;
  logic [COLOR_W-1:0] blend_color;

  // Keyframe memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      time_mem[in_data_i.slot]  <= sat_time(in_data_i.key_time);
      color_mem[in_data_i.slot] <= in_data_i.key_color;
    end
    rd_time_q  <= time_mem[cmd_i.rd_addr];
    rd_color_q <= color_mem[cmd_i.rd_addr];
  end

  // Segment bracket test: previous entry against the one just read
  assign stat_o.hit = (t_q >= prev_time_q) && (t_q <= rd_time_q);

  // Numerator and span of a bracketing segment and of the wrap segment
  assign seg_num   = SPAN_W'(t_q) - SPAN_W'(prev_time_q);
  assign seg_span  = SPAN_W'(rd_time_q) - SPAN_W'(prev_time_q);
  assign wrap_num  = (t_q < rd_time_q)
                   ? SPAN_W'(t_q) + SPAN_W'(TIME_ONE) - SPAN_W'(rd_time_q)
                   : SPAN_W'(t_q) - SPAN_W'(rd_time_q);
  assign wrap_span = SPAN_W'(first_time_q) + SPAN_W'(TIME_ONE) - SPAN_W'(rd_time_q);

  // Restoring division step; quotient settles to zero or one day when trivial
  assign stat_o.div_trivial = (span_q == '0) || (rem_q >= span_q);
  assign rem_shift = {rem_q, 1'b0};
  assign q_bit     = rem_shift >= {1'b0, span_q};
  assign rem_d     = q_bit ? SPAN_W'(rem_shift - {1'b0, span_q}) : rem_shift[SPAN_W-1:0];

  // Four channel blends, red in the top byte
  always_comb begin
    logic [TIME_W-1:0]  wu;
    logic [BLEND_W-1:0] sum;
    wu = TIME_ONE - u_q;
    for (int ch = 0; ch < 4; ch++) begin
      sum = BLEND_W'(from_q[ch*CHAN_W +: CHAN_W]) * BLEND_W'(wu)
          + BLEND_W'(to_q[ch*CHAN_W +: CHAN_W]) * BLEND_W'(u_q);
      blend_color[ch*CHAN_W +: CHAN_W] = sum[TIME_FRAC_BITS +: CHAN_W];
    end
  end

  // Query time and table scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      t_q <= sat_time(in_data_i.time_of_day);
    end
    if (cmd_i.take_first) begin
      first_time_q  <= rd_time_q;
      first_color_q <= rd_color_q;
      prev_time_q   <= rd_time_q;
      prev_color_q  <= rd_color_q;
    end else if (cmd_i.advance) begin
      prev_time_q  <= rd_time_q;
      prev_color_q <= rd_color_q;
    end
  end

  // Segment end colours, divider and blend fraction
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_zero) begin
      from_q <= '0;
      to_q   <= '0;
      u_q    <= '0;
    end else if (cmd_i.set_single) begin
      from_q <= rd_color_q;
      to_q   <= rd_color_q;
      u_q    <= '0;
    end else if (cmd_i.load_seg) begin
      rem_q  <= seg_num;
      span_q <= seg_span;
      from_q <= prev_color_q;
      to_q   <= rd_color_q;
      u_q    <= '0;
    end else if (cmd_i.load_wrap) begin
      rem_q  <= wrap_num;
      span_q <= wrap_span;
      from_q <= rd_color_q;
      to_q   <= first_color_q;
      u_q    <= '0;
    end else if (cmd_i.div_fix) begin
      u_q <= (span_q == '0) ? '0 : TIME_ONE;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      u_q   <= {u_q[TIME_W-2:0], q_bit};
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.red   <= blend_color[3*CHAN_W +: CHAN_W];
      out_q.green <= blend_color[2*CHAN_W +: CHAN_W];
      out_q.blue  <= blend_color[1*CHAN_W +: CHAN_W];
      out_q.alpha <= blend_color[0 +: CHAN_W];
    end
  end

  assign out_data_o = out_q;

endmodule

[rtl/cckr_ctrl.sv]
// Controller of the keyframe ramp: sequences table scan, division and blend,
// and owns the input stall and output valid. Uses cckr_pkg.
module cckr_ctrl
  import cckr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_opcode_i,
  input  logic [COUNT_W-1:0] kf_count_i,
  input  logic               out_stall_i,
  input  cckr_stat_t         stat_i,
  output cckr_cmd_t          cmd_o,
  output logic               in_stall_o,
  output logic               out_valid_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_BLEND = 3'd4;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TIME_FRAC_BITS - 1);

  logic [2:0]           state_q, state_d;
  logic [SLOT_W-1:0]    idx_q, idx_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]   n_kf;
  logic                 at_last;

  // Entries in use, saturated to the table size
  assign n_kf    = (kf_count_i > COUNT_W'(MAX_KEYFRAMES)) ? COUNT_W'(MAX_KEYFRAMES) : kf_count_i;
  assign at_last = ({1'b0, idx_q} == (n_kf - COUNT_W'(1)));

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_opcode_i == OP_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.query   = 1'b1;
            cmd_o.rd_addr = '0;
            if (n_kf == '0) begin
              cmd_o.set_zero = 1'b1;
              state_d        = S_BLEND;
            end else begin
              state_d = S_FIRST;
            end
          end
        end
      end
      S_FIRST: begin
        cmd_o.take_first = 1'b1;
        if (n_kf == COUNT_W'(1)) begin
          cmd_o.set_single = 1'b1;
          state_d          = S_BLEND;
        end else begin
          cmd_o.rd_addr = SLOT_W'(1);
          idx_d         = SLOT_W'(1);
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.load_seg = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end else begin
          cmd_o.advance = 1'b1;
          if (at_last) begin
            cmd_o.load_wrap = 1'b1;
            cnt_d           = '0;
            state_d         = S_DIV;
          end else begin
            cmd_o.rd_addr = idx_q + SLOT_W'(1);
            idx_d         = idx_q + SLOT_W'(1);
          end
        end
      end
      S_DIV: begin
        if (stat_i.div_trivial) begin
          cmd_o.div_fix = 1'b1;
          state_d       = S_BLEND;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_LAST) begin
            state_d = S_BLEND;
          end
        end
      end
      S_BLEND: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/cyclic_color_keyframe_ramp.sv]
// Top level of the cyclic colour keyframe ramp: configuration register and
// APB-style port, controller and datapath. Uses cckr_pkg, cckr_ctrl, cckr_datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o   in_item_t (write or query)
//   out      output     out_valid_o/out_stall_i out_item_t (RGBA colour)
//   cfg      input      psel/penable/pready     keyframe_count at byte 0
//
// A write item is taken without holding off the input. A query with n keyframes
// in use goes straight to the load for n = 0, through a first table read for
// n = 1, and otherwise through a first table read, one read per cycle for the
// segment search, the bit-per-cycle fraction divider, then the load.
// The next item is taken the cycle after the result is loaded, even while the
// result still waits; a stalled result holds the blend until it is taken.
// Reset clears the controller and keyframe_count; the tables need no clearing.
module cyclic_color_keyframe_ramp
  import cckr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [COUNT_W-1:0] kf_count_q;
  logic               cfg_wr;
  cckr_cmd_t          cmd;
  cckr_stat_t         stat;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_KEYFRAME_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kf_count_q <= '0;
    end else if (cfg_wr) begin
      kf_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_KEYFRAME_COUNT) ? APB_DATA_W'(kf_count_q) : '0;

  cckr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .kf_count_i  (kf_count_q),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  cckr_datapath u_datapath (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

[rtl/cckr_checker.sv]
// Port-level checks for the cyclic colour keyframe ramp, bound to the top level.
// Uses cckr_pkg and the macros of cyclic_color_keyframe_ramp_defines.svh.
`include "cyclic_color_keyframe_ramp_defines.svh"

module cckr_checker
  import cckr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // Output transfer rules
  `CCKR_ASSERT(a_out_valid_held, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `CCKR_ASSERT(a_out_data_held, out_valid_o && out_stall_i |=> $stable(out_data_o), "stalled result changed")

  // A write with no result pending never makes one
  `CCKR_ASSERT(a_write_no_result, in_valid_i && !in_stall_o && (in_data_i.opcode == OP_WRITE) && !out_valid_o |=> !out_valid_o, "write item produced a result")

  // A query occupies the block for at least the next cycle
  `CCKR_ASSERT(a_query_busy, in_valid_i && !in_stall_o && (in_data_i.opcode == OP_QUERY) |=> in_stall_o, "query did not hold off the next item")

  // No result shown during reset; unknown before the first reset edge is allowed
  `CCKR_ASSERT_ANY(a_reset_quiet, !rst_ni |-> (out_valid_o !== 1'b1), "result valid during reset")

endmodule

bind cyclic_color_keyframe_ramp cckr_checker u_cckr_checker (.*);
